FILE: sv/nds_pkg.sv
// Shared types, constants and the pixel conversion for the thumbnail downscaler.
`default_nettype none

package nds_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W     = 32;
	localparam int THUMB_W   = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH    = 2'd0,
		CFG_SRC_HEIGHT   = 2'd1,
		CFG_PIXEL_FORMAT = 2'd2
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd480;

	localparam logic FMT_XRGB   = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [PIX_W-1:0]   argb;
		logic [THUMB_W-1:0] x;
		logic [THUMB_W-1:0] y;
		logic               done;
	} result_t;

	// RGB565 channels move to the top of each byte; the low bits stay zero.
	function automatic logic [PIX_W-1:0] to_argb(input logic [PIX_W-1:0] px, input logic fmt);
		logic [PIX_W-1:0] res;
		if (fmt == FMT_RGB565) begin
			res = {ALPHA_OPAQUE, px[15:11], 3'b000, px[10:5], 2'b00, px[4:0], 3'b000};
		end else begin
			res = {ALPHA_OPAQUE, px[23:0]};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: sv/nds_select.sv
// Source and thumbnail position tracking and nearest-neighbor pixel selection.
`default_nettype none

module nds_select #(
	parameter int OUT_WIDTH   = 128,
	parameter int OUT_HEIGHT  = 128,
	parameter int MAX_SRC_DIM = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [nds_pkg::PIX_W-1:0]  src_pixel,
	input  wire logic                       frame_start,
	input  wire logic [nds_pkg::CFG_W-1:0]  cfg_width,
	input  wire logic [nds_pkg::CFG_W-1:0]  cfg_height,
	input  wire logic                       cfg_format,
	output logic                            hit,
	output nds_pkg::result_t                res
);
	import nds_pkg::*;

	localparam int DIM_W   = $clog2(MAX_SRC_DIM + 1);
	localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int COL_W   = $clog2(MAX_SRC_DIM);
	localparam int TC_W    = $clog2(OUT_WIDTH);
	localparam int TR_W    = $clog2(OUT_HEIGHT + 1);
	localparam int ACC_C_W = $clog2(MAX_SRC_DIM * OUT_WIDTH + 1);
	localparam int ACC_R_W = $clog2(MAX_SRC_DIM * OUT_HEIGHT + 1);

	logic [COL_W-1:0]   src_col_q,  cur_col,  nxt_col;
	logic [DIM_W-1:0]   src_row_q,  cur_row,  nxt_row;
	logic [TC_W-1:0]    th_col_q,   cur_tcol, nxt_tcol;
	logic [TR_W-1:0]    th_row_q,   cur_trow, nxt_trow;
	logic [ACC_C_W-1:0] acc_c_q,    cur_accc, nxt_accc;
	logic [ACC_R_W-1:0] acc_r_q,    cur_accr, nxt_accr;
	// Scaled source positions: column times OUT_WIDTH and row times OUT_HEIGHT.
	logic [ACC_C_W-1:0] base_c_q,   cur_basec, nxt_basec;
	logic [ACC_R_W-1:0] base_r_q,   cur_baser, nxt_baser;

	logic [CMP_W-1:0] w_ext, h_ext, w_cl, h_cl;
	logic [DIM_W-1:0] w_dim, h_dim;
	logic             active, row_hit, col_hit, sel;
	logic [ACC_C_W-1:0] diff_c;
	logic [ACC_R_W-1:0] diff_r;

	// Dimensions in use are saturated into the range that never upscales.
	always_comb begin
		w_ext = CMP_W'(cfg_width);
		h_ext = CMP_W'(cfg_height);
		if (w_ext > CMP_W'(MAX_SRC_DIM)) begin
			w_cl = CMP_W'(MAX_SRC_DIM);
		end else if (w_ext < CMP_W'(OUT_WIDTH)) begin
			w_cl = CMP_W'(OUT_WIDTH);
		end else begin
			w_cl = w_ext;
		end
		if (h_ext > CMP_W'(MAX_SRC_DIM)) begin
			h_cl = CMP_W'(MAX_SRC_DIM);
		end else if (h_ext < CMP_W'(OUT_HEIGHT)) begin
			h_cl = CMP_W'(OUT_HEIGHT);
		end else begin
			h_cl = h_ext;
		end
		w_dim = DIM_W'(w_cl);
		h_dim = DIM_W'(h_cl);
	end

	always_comb begin
		cur_col   = frame_start ? '0 : src_col_q;
		cur_row   = frame_start ? '0 : src_row_q;
		cur_tcol  = frame_start ? '0 : th_col_q;
		cur_trow  = frame_start ? '0 : th_row_q;
		cur_accc  = frame_start ? '0 : acc_c_q;
		cur_accr  = frame_start ? '0 : acc_r_q;
		cur_basec = frame_start ? '0 : base_c_q;
		cur_baser = frame_start ? '0 : base_r_q;

		active = (cur_row < h_dim);
		diff_c = cur_accc - cur_basec;
		diff_r = cur_accr - cur_baser;
		// floor(acc / OUT) == pos  <=>  pos*OUT <= acc < pos*OUT + OUT
		col_hit = (cur_accc >= cur_basec) && (diff_c < ACC_C_W'(OUT_WIDTH));
		row_hit = (cur_accr >= cur_baser) && (diff_r < ACC_R_W'(OUT_HEIGHT));
		sel = active && (cur_trow < TR_W'(OUT_HEIGHT)) && row_hit && col_hit;
		hit = accept && sel;

		res.argb = to_argb(src_pixel, cfg_format);
		res.x    = THUMB_W'(cur_tcol);
		res.y    = THUMB_W'(cur_trow);
		res.done = (cur_trow == TR_W'(OUT_HEIGHT - 1)) && (cur_tcol == TC_W'(OUT_WIDTH - 1));

		nxt_col   = cur_col;
		nxt_row   = cur_row;
		nxt_tcol  = cur_tcol;
		nxt_trow  = cur_trow;
		nxt_accc  = cur_accc;
		nxt_accr  = cur_accr;
		nxt_basec = cur_basec;
		nxt_baser = cur_baser;

		if (sel) begin
			if (cur_tcol == TC_W'(OUT_WIDTH - 1)) begin
				nxt_tcol = '0;
				nxt_accc = '0;
				nxt_trow = cur_trow + TR_W'(1);
				nxt_accr = cur_accr + ACC_R_W'(h_dim);
			end else begin
				nxt_tcol = cur_tcol + TC_W'(1);
				nxt_accc = cur_accc + ACC_C_W'(w_dim);
			end
		end

		if (active) begin
			if ((DIM_W'(cur_col) + DIM_W'(1)) >= w_dim) begin
				nxt_col   = '0;
				nxt_basec = '0;
				nxt_row   = cur_row + DIM_W'(1);
				nxt_baser = cur_baser + ACC_R_W'(OUT_HEIGHT);
			end else begin
				nxt_col   = cur_col + COL_W'(1);
				nxt_basec = cur_basec + ACC_C_W'(OUT_WIDTH);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			th_col_q  <= '0;
			th_row_q  <= '0;
			acc_c_q   <= '0;
			acc_r_q   <= '0;
			base_c_q  <= '0;
			base_r_q  <= '0;
		end else if (accept) begin
			src_col_q <= nxt_col;
			src_row_q <= nxt_row;
			th_col_q  <= nxt_tcol;
			th_row_q  <= nxt_trow;
			acc_c_q   <= nxt_accc;
			acc_r_q   <= nxt_accr;
			base_c_q  <= nxt_basec;
			base_r_q  <= nxt_baser;
		end
	end

endmodule

`default_nettype wire

FILE: sv/nds_skid.sv
// Output register with a skid stage so the input side keeps moving during a stall.
`default_nettype none

module nds_skid (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire nds_pkg::result_t  push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output nds_pkg::result_t       out_data
);
	import nds_pkg::*;

	logic    main_vld_q, skid_vld_q;
	result_t main_q, skid_q;
	logic    take;

	assign take      = main_vld_q && !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	// A push never meets a full skid stage, since full stalls the input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || take) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || take) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: sv/nearest_downscale_rgb565_to_argb.sv
// Nearest-neighbor downscaler from a raster source frame to an ARGB8888 thumbnail.
//
// Source pixels enter on the in channel (in_valid / in_stall), one per transfer, with
// frame_start marking the first pixel of a frame. Each pixel whose position lands on a
// thumbnail sample point leaves on the out channel (out_valid / out_stall) as an opaque
// ARGB8888 pixel with its thumbnail column and row; frame_done flags the last one.
// Other pixels are consumed with no output transfer.
// The block takes one source pixel every cycle while in_stall is low. Results leave from
// the output register. The selection logic compares incremental position accumulators,
// so no pixel ever waits on arithmetic. When the receiver stalls, the next result goes
// to a skid register; in_stall rises only once that register holds a result too, and
// drops the cycle after the stall clears. Source width, height and pixel format are
// written through the cfg port; the user must write them only while the block is idle,
// which the block itself does not enforce. Reset clears all position counters, empties
// the output, and loads a 640x480 XRGB source format.
`default_nettype none

module nearest_downscale_rgb565_to_argb #(
	parameter int OUT_WIDTH   = 128,
	parameter int OUT_HEIGHT  = 128,
	parameter int MAX_SRC_DIM = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [nds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nds_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [nds_pkg::PIX_W-1:0]     src_pixel,
	input  wire logic                          frame_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [nds_pkg::PIX_W-1:0]          argb_pixel,
	output logic [nds_pkg::THUMB_W-1:0]        thumb_x,
	output logic [nds_pkg::THUMB_W-1:0]        thumb_y,
	output logic                               frame_done
);
	import nds_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic             format_q;
	logic             accept, hit;
	result_t          sel_res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SRC_WIDTH_RST;
			height_q <= SRC_HEIGHT_RST;
			format_q <= FMT_XRGB;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:    width_q  <= cfg_data;
				CFG_SRC_HEIGHT:   height_q <= cfg_data;
				CFG_PIXEL_FORMAT: format_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && !in_stall;

	nds_select #(
		.OUT_WIDTH   (OUT_WIDTH),
		.OUT_HEIGHT  (OUT_HEIGHT),
		.MAX_SRC_DIM (MAX_SRC_DIM)
	) u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.src_pixel   (src_pixel),
		.frame_start (frame_start),
		.cfg_width   (width_q),
		.cfg_height  (height_q),
		.cfg_format  (format_q),
		.hit         (hit),
		.res         (sel_res)
	);

	nds_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (hit),
		.push_data (sel_res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign argb_pixel = out_res.argb;
	assign thumb_x    = out_res.x;
	assign thumb_y    = out_res.y;
	assign frame_done = out_res.done;

endmodule

`default_nettype wire
